FILE: rtl/mscp_pkg.sv
// Shared types and constants for the MPEG start code parser.
// No dependencies; used by every module under rtl/.
package mscp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DIM_W    = 12;
    localparam int unsigned RATE_W   = 4;
    localparam int unsigned PKIND_W  = 2;
    localparam int unsigned KIND_W   = 3;
    // start_code + width + height + rate + picture kind = 38 bits, padded to 40
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned OUT_USED_W = BYTE_W + 2 * DIM_W + RATE_W + PKIND_W;

    // Start code bytes and ranges
    localparam logic [7:0] SC_PICTURE   = 8'h00;
    localparam logic [7:0] SC_PREFIX_1  = 8'h01;
    localparam logic [7:0] SC_SLICE_MAX = 8'hAF;
    localparam logic [7:0] SC_SEQUENCE  = 8'hB3;
    localparam logic [7:0] SC_GOP       = 8'hB8;
    localparam logic [7:0] SC_PACK      = 8'hBA;
    localparam logic [7:0] SC_SYSTEM    = 8'hBB;
    localparam logic [7:0] SC_AUDIO_LO  = 8'hC0;
    localparam logic [7:0] SC_AUDIO_HI  = 8'hDF;
    localparam logic [7:0] SC_VIDEO_LO  = 8'hE0;
    localparam logic [7:0] SC_VIDEO_HI  = 8'hEF;

    localparam logic [7:0] PIC_TYPE_MASK = 8'h38;
    localparam logic [7:0] RATE_MASK     = 8'h0F;
    localparam logic [RATE_W-1:0] RATE_OTHER = 4'd8;

    // Picture coding type field values
    localparam logic [2:0] PCT_I = 3'd1;
    localparam logic [2:0] PCT_P = 3'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PACK     = 3'd0,
        KIND_SYSTEM   = 3'd1,
        KIND_SEQUENCE = 3'd2,
        KIND_GOP      = 3'd3,
        KIND_PICTURE  = 3'd4,
        KIND_SLICE    = 3'd5,
        KIND_AUDIO    = 3'd6,
        KIND_VIDEO    = 3'd7
    } t_kind;

    typedef enum logic [PKIND_W-1:0] {
        PK_I     = 2'd0,
        PK_P     = 2'd1,
        PK_OTHER = 2'd2
    } t_pic_kind;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'b001,
        PH_CODE    = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [BYTE_W-1:0]   start_code;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [RATE_W-1:0]   rate_sel;
        t_pic_kind           pic_kind;
    } t_result;

endpackage

FILE: rtl/mscp_parse.sv
// Start code scanner and header decoder: parse state plus the result decode.
// Depends on mscp_pkg.
module mscp_parse (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  logic [7:0]               i_byte,
    output mscp_pkg::t_result        o_res
);
    import mscp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_zero_run, n_zero_run;
    logic [1:0]  r_count, n_count;
    logic        r_is_seq, n_is_seq;
    logic [7:0]  r_pay [3];
    logic [2:0]  pic_type;
    logic [3:0]  rate_raw;
    logic        pay_last;

    assign pic_type = 3'((i_byte & PIC_TYPE_MASK) >> 3);
    assign rate_raw = 4'(i_byte & RATE_MASK);
    assign pay_last = r_is_seq ? (r_count == 2'd3) : (r_count == 2'd1);

    always_comb begin
        n_phase    = r_phase;
        n_zero_run = r_zero_run;
        n_count    = r_count;
        n_is_seq   = r_is_seq;
        o_res      = '0;
        o_res.start_code = i_byte;
        unique case (r_phase)
            PH_CODE: begin
                n_phase    = PH_SEARCH;
                n_zero_run = 2'd0;
                priority if (i_byte == SC_SEQUENCE || i_byte == SC_PICTURE) begin
                    n_phase  = PH_PAYLOAD;
                    n_count  = 2'd0;
                    n_is_seq = (i_byte == SC_SEQUENCE);
                end else if (i_byte == SC_PACK) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_PACK;
                end else if (i_byte == SC_SYSTEM) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_SYSTEM;
                end else if (i_byte == SC_GOP) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_GOP;
                end else if (i_byte <= SC_SLICE_MAX) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_SLICE;
                end else if (i_byte >= SC_AUDIO_LO && i_byte <= SC_AUDIO_HI) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_AUDIO;
                end else if (i_byte >= SC_VIDEO_LO && i_byte <= SC_VIDEO_HI) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_VIDEO;
                end else begin
                    o_res.valid = 1'b0;
                end
            end
            PH_PAYLOAD: begin
                if (!pay_last) begin
                    n_count = r_count + 2'd1;
                end else begin
                    n_phase    = PH_SEARCH;
                    n_zero_run = 2'd0;
                    n_count    = 2'd0;
                    o_res.valid = 1'b1;
                    if (r_is_seq) begin
                        o_res.kind       = KIND_SEQUENCE;
                        o_res.start_code = SC_SEQUENCE;
                        o_res.width      = {r_pay[0], r_pay[1][7:4]};
                        o_res.height     = {r_pay[1][3:0], r_pay[2]};
                        o_res.rate_sel   = (rate_raw == 4'd0 || rate_raw[3]) ?
                                           RATE_OTHER : rate_raw;
                    end else begin
                        o_res.kind       = KIND_PICTURE;
                        o_res.start_code = SC_PICTURE;
                        o_res.pic_kind   = (pic_type == PCT_I) ? PK_I :
                                           (pic_type == PCT_P) ? PK_P : PK_OTHER;
                    end
                end
            end
            default: begin
                n_phase = PH_SEARCH;
                if (i_byte == SC_PREFIX_1 && r_zero_run == 2'd2) begin
                    n_phase    = PH_CODE;
                    n_zero_run = 2'd0;
                end else if (i_byte == SC_PICTURE) begin
                    if (r_zero_run != 2'd2) n_zero_run = r_zero_run + 2'd1;
                end else begin
                    n_zero_run = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEARCH;
            r_zero_run <= 2'd0;
            r_count    <= 2'd0;
            r_is_seq   <= 1'b0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_zero_run <= n_zero_run;
            r_count    <= n_count;
            r_is_seq   <= n_is_seq;
        end
    end

    // payload capture; only the first three bytes are kept
    always_ff @(posedge i_clk) begin
        if (i_advance && r_phase == PH_PAYLOAD && !pay_last && r_count != 2'd3) begin
            r_pay[r_count] <= i_byte;
        end
    end

endmodule

FILE: rtl/mscp_out_reg.sv
// Result register for the master stream side; packs the result into tdata/tuser.
// Depends on mscp_pkg.
module mscp_out_reg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  mscp_pkg::t_result                 i_res,
    input  logic                              i_ready,
    output logic                              o_free,
    output logic                              o_valid,
    output logic [mscp_pkg::KIND_W-1:0]       o_user,
    output logic [mscp_pkg::OUT_DATA_W-1:0]   o_data
);
    import mscp_pkg::*;

    logic                  r_valid, n_valid;
    logic [KIND_W-1:0]     r_user;
    logic [OUT_DATA_W-1:0] r_data;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load)       n_valid = i_res.valid;
        else if (i_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_user <= i_res.kind;
            r_data <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, i_res.pic_kind,
                       i_res.rate_sel, i_res.height, i_res.width, i_res.start_code};
        end
    end

    assign o_valid = r_valid;
    assign o_user  = r_user;
    assign o_data  = r_data;

endmodule

FILE: rtl/mpeg_start_code_parser.sv
// Top level of the MPEG-1/2 start code parser: input register, parser, result register.
// Depends on mscp_pkg, mscp_parse and mscp_out_reg.
//
//  channel  | dir | beat payload
//  ---------+-----+--------------------------------------------------------------
//  s_axis   | in  | tdata[7:0] stream byte
//  m_axis   | out | tuser unit kind; tdata start code, width, height, rate, pic kind
//
// One byte per clock sustained while m_axis is not stalled. A byte is held in the input
// register, then the parser state and decode update and any result lands in the output
// register. Reset is synchronous, active low, and drops both stage valids and returns
// the scanner to searching. A stalled output holds the input stage; the input register
// is refilled in the same cycle its byte moves on.
module mpeg_start_code_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] in_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] start_code, [19:8] frame_width, [31:20] frame_height,
    // [35:32] frame_rate_sel, [37:36] picture_kind, [39:38] zero
    output logic [mscp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [mscp_pkg::KIND_W-1:0]       m_axis_tuser    // [2:0] unit_kind
);
    import mscp_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       advance;
    t_result    res;

    // byte leaves the input register when the result slot can take it
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) n_in_valid = s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_valid <= 1'b0;
        else          r_in_valid <= n_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in_byte <= s_axis_tdata;
    end

    mscp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_res     (res)
    );

    mscp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_res    (res),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_user   (m_axis_tuser),
        .o_data   (m_axis_tdata)
    );

    // input stage only backpressures while holding a byte
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stage stalled while empty");

    // a new result appears only in the cycle after a byte moved on
    a_out_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)) |-> $past(advance))
        else $error("result without a parsed byte");

    // dimensions and rate only on sequence results
    a_seq_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_SEQUENCE) |->
        (m_axis_tdata[35:8] == '0))
        else $error("sequence fields on a non-sequence result");

    // sequence and picture results carry their own code byte
    a_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_SEQUENCE || m_axis_tuser == KIND_PICTURE))
        |-> (m_axis_tdata[7:0] ==
             ((m_axis_tuser == KIND_SEQUENCE) ? SC_SEQUENCE : SC_PICTURE)))
        else $error("start code does not match unit kind");

endmodule

FILE: verif/tb_mpeg_start_code_parser.sv
// Self-checking testbench for mpeg_start_code_parser: byte stream in, unit records out.
// Depends on mscp_pkg and the RTL under rtl/; holds its own parser model as a scoreboard.
module tb_mpeg_start_code_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import mscp_pkg::*;

    localparam int unsigned STREAM_BYTES = 850;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PCT     = 36;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam logic [7:0] ZERO_BYTE   = 8'h00;
    localparam logic [7:0] SC_RESERVED = 8'hF0;

    // Opening stream: sequence header with all-ones size and a rate nibble above seven
    // behind a three-zero prefix; an I picture whose first payload byte is zero; an
    // unlisted code; a slice whose code byte is 01, followed by 00 01 E0 to show the
    // code byte does not count toward a new prefix.
    localparam logic [7:0] OPENING [26] = '{
        ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, SC_PREFIX_1, SC_SEQUENCE,
        8'hFF, 8'hFF, 8'hFF, 8'h0F,
        ZERO_BYTE, ZERO_BYTE, SC_PREFIX_1, SC_PICTURE, 8'h00, 8'h08,
        ZERO_BYTE, ZERO_BYTE, SC_PREFIX_1, SC_RESERVED,
        ZERO_BYTE, ZERO_BYTE, SC_PREFIX_1, SC_PREFIX_1,
        ZERO_BYTE, SC_PREFIX_1, SC_VIDEO_LO
    };

    typedef struct {
        t_kind       kind;
        logic [7:0]  code;
        logic [11:0] width;
        logic [11:0] height;
        logic [3:0]  rate;
        t_pic_kind   pic;
    } t_unit_rec;

    // Parser model plus the queue of units still owed by the block.
    class unit_scoreboard;
        t_unit_rec   units_due[$];
        int unsigned fails;
        t_phase      phase;
        logic [1:0]  zero_run;
        logic [2:0]  pay_idx;
        logic [7:0]  held_code;
        logic [7:0]  held [3];

        function new();
            fails     = 0;
            phase     = PH_SEARCH;
            zero_run  = '0;
            pay_idx   = '0;
            held_code = '0;
            held      = '{default: '0};
        endfunction

        // Advance the model by one accepted stream byte; queue any unit it completes.
        function void note_byte(logic [7:0] b);
            t_unit_rec  u;
            logic [2:0] need;
            logic [7:0] masked;
            logic [2:0] ctype;
            logic [3:0] rate;
            bit         hit;
            hit      = 1'b0;
            u.kind   = KIND_PACK;
            u.code   = b;
            u.width  = '0;
            u.height = '0;
            u.rate   = '0;
            u.pic    = PK_I;
            case (phase)
                PH_CODE: begin
                    phase    = PH_SEARCH;
                    zero_run = '0;
                    if (b == SC_SEQUENCE || b == SC_PICTURE) begin
                        held_code = b;
                        pay_idx   = '0;
                        phase     = PH_PAYLOAD;
                    end else begin
                        hit = 1'b1;
                        if (b == SC_PACK)
                            u.kind = KIND_PACK;
                        else if (b == SC_SYSTEM)
                            u.kind = KIND_SYSTEM;
                        else if (b == SC_GOP)
                            u.kind = KIND_GOP;
                        else if (b <= SC_SLICE_MAX)
                            u.kind = KIND_SLICE;
                        else if (b >= SC_AUDIO_LO && b <= SC_AUDIO_HI)
                            u.kind = KIND_AUDIO;
                        else if (b >= SC_VIDEO_LO && b <= SC_VIDEO_HI)
                            u.kind = KIND_VIDEO;
                        else
                            hit = 1'b0;
                    end
                end
                PH_PAYLOAD: begin
                    need = (held_code == SC_SEQUENCE) ? 3'd4 : 3'd2;
                    if (pay_idx + 3'd1 < need) begin
                        if (pay_idx < 3'd3)
                            held[pay_idx] = b;
                        pay_idx = pay_idx + 3'd1;
                    end else begin
                        phase    = PH_SEARCH;
                        zero_run = '0;
                        pay_idx  = '0;
                        hit      = 1'b1;
                        u.code   = held_code;
                        if (held_code == SC_SEQUENCE) begin
                            u.kind   = KIND_SEQUENCE;
                            u.width  = {held[0], held[1][7:4]};
                            u.height = {held[1][3:0], held[2]};
                            masked   = b & RATE_MASK;
                            rate     = masked[3:0];
                            if (rate == 4'd0 || rate > 4'd7)
                                rate = RATE_OTHER;
                            u.rate = rate;
                        end else begin
                            u.kind = KIND_PICTURE;
                            masked = b & PIC_TYPE_MASK;
                            ctype  = masked[5:3];
                            if (ctype == PCT_I)
                                u.pic = PK_I;
                            else if (ctype == PCT_P)
                                u.pic = PK_P;
                            else
                                u.pic = PK_OTHER;
                        end
                    end
                end
                default: begin
                    phase = PH_SEARCH;
                    if (b == SC_PREFIX_1 && zero_run >= 2'd2) begin
                        phase    = PH_CODE;
                        zero_run = '0;
                    end else if (b == ZERO_BYTE) begin
                        if (zero_run < 2'd2)
                            zero_run = zero_run + 2'd1;
                    end else begin
                        zero_run = '0;
                    end
                end
            endcase
            if (hit)
                units_due.push_back(u);
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                fails++;
            end
        endfunction

        // Compare one output beat against the oldest owed unit.
        function void check_unit(logic [KIND_W-1:0] kind_bits,
                                 logic [OUT_DATA_W-1:0] data);
            t_unit_rec u;
            if (units_due.size() == 0) begin
                $error("unit with no byte to explain it: kind %0d code 0x%0h",
                       kind_bits, data[7:0]);
                fails++;
                return;
            end
            u = units_due.pop_front();
            cmp_field("unit_kind",      u.kind,   kind_bits);
            cmp_field("start_code",     u.code,   data[7:0]);
            cmp_field("frame_width",    u.width,  data[19:8]);
            cmp_field("frame_height",   u.height, data[31:20]);
            cmp_field("frame_rate_sel", u.rate,   data[35:32]);
            cmp_field("picture_kind",   u.pic,    data[37:36]);
            cmp_field("tdata_pad",      0,        data[39:38]);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] in_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [7:0] start_code, [19:8] frame_width, [31:20] frame_height,
    // [35:32] frame_rate_sel, [37:36] picture_kind, [39:38] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;   // [2:0] unit_kind

    unit_scoreboard sb = new();
    int unsigned    bytes_sent;
    bit             steady;                // both sides run without gaps while set

    mpeg_start_code_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one byte, with random gaps ahead of it, and hold it until the beat is taken.
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Mostly well-formed units with random content; the rest is noise rich in 00 and 01,
    // which also breaks off prefixes and feeds them odd code bytes.
    task automatic send_unit();
        logic [7:0]  q[$];
        int unsigned r;
        if ($urandom_range(99) < 80) begin
            repeat ($urandom_range(2, 4))
                q.push_back(ZERO_BYTE);
            q.push_back(SC_PREFIX_1);
            case ($urandom_range(9))
                0: q.push_back(SC_PACK);
                1: q.push_back(SC_SYSTEM);
                2: begin
                    q.push_back(SC_SEQUENCE);
                    repeat (4)
                        q.push_back(8'($urandom_range(255)));
                end
                3: q.push_back(SC_GOP);
                4: begin
                    q.push_back(SC_PICTURE);
                    repeat (2)
                        q.push_back(8'($urandom_range(255)));
                end
                5: q.push_back(8'($urandom_range(SC_PREFIX_1, SC_SLICE_MAX)));
                6: q.push_back(8'($urandom_range(SC_AUDIO_LO, SC_AUDIO_HI)));
                7: q.push_back(8'($urandom_range(SC_VIDEO_LO, SC_VIDEO_HI)));
                8: begin
                    // unlisted: B0-B2, B4-B7, B9, BC-BF, F0-FF
                    r = $urandom_range(27);
                    if (r < 3)
                        q.push_back(8'(8'hB0 + r));
                    else if (r < 7)
                        q.push_back(8'(8'hB4 + r - 3));
                    else if (r == 7)
                        q.push_back(8'hB9);
                    else if (r < 12)
                        q.push_back(8'(8'hBC + r - 8));
                    else
                        q.push_back(8'(SC_RESERVED + r - 12));
                end
                default: q.push_back(8'($urandom_range(255)));
            endcase
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(3))
                    0:       q.push_back(ZERO_BYTE);
                    1:       q.push_back(SC_PREFIX_1);
                    default: q.push_back(8'($urandom_range(255)));
                endcase
            end
        end
        foreach (q[i])
            send_byte(q[i]);
    endtask

    // Stimulus and end of run.
    initial begin : stim
        bytes_sent    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        steady        <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING[i])
            send_byte(OPENING[i]);

        while (bytes_sent < STREAM_BYTES) begin
            steady <= (bytes_sent >= 400 && bytes_sent < 560);
            send_unit();
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every owed unit, then idle for DRAIN_CYCLES to catch anything extra.
        while (sb.units_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fails == 0)
            $display("** mpeg_start_code_parser: PASSED **");
        else
            $display("** mpeg_start_code_parser: FAILED **");
        $finish;
    end

    // Output side: check each beat, stall at random, and once hold off long enough
    // for both pipeline stages to fill and tready on the input to drop.
    initial begin : sink
        int unsigned hold_left;
        int unsigned units_seen;
        bit          held_done;
        hold_left     = 0;
        units_seen    = 0;
        held_done     = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_unit(m_axis_tuser, m_axis_tdata);
                units_seen++;
            end
            if (!held_done && units_seen >= 20) begin
                hold_left = HOLD_CYCLES;
                held_done = 1'b1;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** mpeg_start_code_parser: FAILED **");
                $finish;
            end
        end
    end

endmodule
